>>> rtl/core/pc_pkg.sv
// ----------------------------------------------------------------------------
// pc_pkg: shared types and constants
// Command struct, product sequence codes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CORR_W   = 16;
    localparam int COUNT_W  = 13;
    localparam int FRAC_BITS = 15;

    typedef logic [2:0] t_op;

    localparam t_op OP_NXY  = 3'd0;
    localparam t_op OP_SXSY = 3'd1;
    localparam t_op OP_NXX  = 3'd2;
    localparam t_op OP_SXSX = 3'd3;
    localparam t_op OP_NYY  = 3'd4;
    localparam t_op OP_SYSY = 3'd5;
    localparam t_op OP_VV   = 3'd6;

    typedef struct packed {
        logic acc;
        logic mul_start;
        logic mul_step;
        logic mul_fin;
        t_op  op;
        logic sq_start;
        logic sq_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/core/pc_if.sv
// ----------------------------------------------------------------------------
// pc_if: stream channels
// Input sample channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pc_pkg::SAMPLE_W-1:0]  x_sample;
    logic signed [pc_pkg::SAMPLE_W-1:0]  y_sample;
    logic                                last;

    modport source (output valid, x_sample, y_sample, last, input ready);
    modport sink   (input valid, x_sample, y_sample, last, output ready);
endinterface

interface pc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pc_pkg::CORR_W-1:0]    correlation;
    logic                                degenerate;
    logic                                overflow;
    logic [pc_pkg::COUNT_W-1:0]          sample_count;

    modport source (output valid, correlation, degenerate, overflow, sample_count,
                    input ready);
    modport sink   (input valid, correlation, degenerate, overflow, sample_count,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/pc_datapath.sv
// ----------------------------------------------------------------------------
// pc_datapath: sums, shared multiplier, square root and divider
// Accumulates moments, forms C, Vx, Vy, sqrt(Vx*Vy) and the Q1.15 quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pc_datapath #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  pc_pkg::t_cmd                      i_cmd,
    input  wire signed [pc_pkg::SAMPLE_W-1:0] i_x_sample,
    input  wire signed [pc_pkg::SAMPLE_W-1:0] i_y_sample,
    output logic signed [pc_pkg::CORR_W-1:0]  o_correlation,
    output logic                              o_degenerate,
    output logic                              o_overflow,
    output logic [pc_pkg::COUNT_W-1:0]        o_sample_count
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = 2 * SAMPLE_BITS + CW;
    localparam int PW = 2 * SAMPLE_BITS + 2 * CW + 1;
    localparam int QB = pc_pkg::FRAC_BITS + 1;

    logic [CW-1:0]           r_count;
    logic signed [SW-1:0]    r_sx, r_sy;
    logic signed [QW-1:0]    r_sxx, r_syy, r_sxy;
    logic                    r_drop;

    logic signed [PW-1:0]    r_c, r_vx, r_vy;
    logic [2*PW-1:0]         r_mcand, r_macc;
    logic [PW-1:0]           r_mplier;
    logic                    r_psign;

    logic [2*PW-1:0]         r_sop, r_sres, r_sone;

    logic [PW:0]             r_rem;
    logic [PW-1:0]           r_d;
    logic [QB-1:0]           r_q;
    logic                    r_csign;

    logic [31:0]             x_z, y_z;
    logic signed [SAMPLE_BITS-1:0]   xe, ye;
    logic signed [2*SAMPLE_BITS-1:0] p_xx, p_yy, p_xy;

    logic signed [PW-1:0]    opa, opb, pv;
    logic [PW-1:0]           ma, mb, cmag;
    logic [2*PW-1:0]         s_try;
    logic [PW:0]             rem_sh;
    logic                    degen;
    logic [QB-1:0]           q_pos;
    logic [QB:0]             q_neg;

    assign x_z  = 32'($unsigned(i_x_sample));
    assign y_z  = 32'($unsigned(i_y_sample));
    assign xe   = $signed(x_z[SAMPLE_BITS-1:0]);
    assign ye   = $signed(y_z[SAMPLE_BITS-1:0]);
    assign p_xx = xe * xe;
    assign p_yy = ye * ye;
    assign p_xy = xe * ye;

    always_comb begin
        unique case (i_cmd.op)
            pc_pkg::OP_NXY: begin
                opa = PW'($signed({1'b0, r_count}));
                opb = PW'(r_sxy);
            end
            pc_pkg::OP_SXSY: begin
                opa = PW'(r_sx);
                opb = PW'(r_sy);
            end
            pc_pkg::OP_NXX: begin
                opa = PW'($signed({1'b0, r_count}));
                opb = PW'(r_sxx);
            end
            pc_pkg::OP_SXSX: begin
                opa = PW'(r_sx);
                opb = PW'(r_sx);
            end
            pc_pkg::OP_NYY: begin
                opa = PW'($signed({1'b0, r_count}));
                opb = PW'(r_syy);
            end
            pc_pkg::OP_SYSY: begin
                opa = PW'(r_sy);
                opb = PW'(r_sy);
            end
            pc_pkg::OP_VV: begin
                opa = r_vx[PW-1] ? '0 : r_vx;
                opb = r_vy[PW-1] ? '0 : r_vy;
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign ma     = opa[PW-1] ? $unsigned(-opa) : $unsigned(opa);
    assign mb     = opb[PW-1] ? $unsigned(-opb) : $unsigned(opb);
    assign pv     = r_psign ? -$signed(r_macc[PW-1:0]) : $signed(r_macc[PW-1:0]);
    assign s_try  = r_sres | r_sone;
    assign cmag   = r_c[PW-1] ? $unsigned(-r_c) : $unsigned(r_c);
    assign rem_sh = {r_rem[PW-1:0], 1'b0};
    assign degen  = (r_count == '0) || (r_d == '0);
    assign q_pos  = (r_q > QB'(32767)) ? QB'(32767) : r_q;
    assign q_neg  = (r_q > QB'(32768)) ? (QB+1)'(32768) : (QB+1)'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.acc) begin
            if (r_count < CW'(MAX_SAMPLES)) begin
                r_count <= r_count + CW'(1);
                r_sx    <= r_sx + SW'(xe);
                r_sy    <= r_sy + SW'(ye);
                r_sxx   <= r_sxx + QW'(p_xx);
                r_syy   <= r_syy + QW'(p_yy);
                r_sxy   <= r_sxy + QW'(p_xy);
            end else begin
                r_drop  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mcand  <= (2*PW)'(ma);
            r_mplier <= mb;
            r_macc   <= '0;
            r_psign  <= opa[PW-1] ^ opb[PW-1];
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_macc <= r_macc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
        if (i_cmd.mul_fin) begin
            case (i_cmd.op)
                pc_pkg::OP_NXY:  r_c  <= pv;
                pc_pkg::OP_SXSY: r_c  <= r_c - pv;
                pc_pkg::OP_NXX:  r_vx <= pv;
                pc_pkg::OP_SXSX: r_vx <= r_vx - pv;
                pc_pkg::OP_NYY:  r_vy <= pv;
                pc_pkg::OP_SYSY: r_vy <= r_vy - pv;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_start) begin
            r_sop  <= r_macc;
            r_sres <= '0;
            r_sone <= (2*PW)'(1) << (2*PW-2);
        end else if (i_cmd.sq_step) begin
            if (r_sop >= s_try) begin
                r_sop  <= r_sop - s_try;
                r_sres <= (r_sres >> 1) | r_sone;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sone <= r_sone >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_d     <= r_sres[PW-1:0];
            r_csign <= r_c[PW-1];
            if (cmag >= r_sres[PW-1:0]) begin
                r_rem <= (PW+1)'(cmag - r_sres[PW-1:0]);
                r_q   <= QB'(1);
            end else begin
                r_rem <= (PW+1)'(cmag);
                r_q   <= '0;
            end
        end else if (i_cmd.div_step) begin
            if (rem_sh >= (PW+1)'(r_d)) begin
                r_rem <= rem_sh - (PW+1)'(r_d);
                r_q   <= {r_q[QB-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_degenerate   <= degen;
            o_overflow     <= r_drop;
            o_sample_count <= pc_pkg::COUNT_W'(r_count);
            if (degen) begin
                o_correlation <= '0;
            end else if (r_csign) begin
                o_correlation <= pc_pkg::CORR_W'(-$signed(q_neg));
            end else begin
                o_correlation <= $signed(pc_pkg::CORR_W'(q_pos));
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pc_ctrl.sv
// ----------------------------------------------------------------------------
// pc_ctrl: sequencer
// Runs accumulation, the product sequence, square root, divide and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pc_ctrl #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire           i_in_last,
    input  wire           i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output pc_pkg::t_cmd  o_cmd
);

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int PW   = 2 * SAMPLE_BITS + 2 * CW + 1;
    localparam int CNTW = $clog2(PW + 1);

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_MLOAD = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MFIN  = 4'd3;
    localparam logic [3:0] S_SLOAD = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DLOAD = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    pc_pkg::t_op      r_op, n_op;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_in_last) begin
                        n_op    = pc_pkg::OP_NXY;
                        n_state = S_MLOAD;
                    end
                end
            end
            S_MLOAD: begin
                o_cmd.mul_start = 1'b1;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(PW - 1)) begin
                    n_state = S_MFIN;
                end
            end
            S_MFIN: begin
                o_cmd.mul_fin = 1'b1;
                if (r_op == pc_pkg::OP_VV) begin
                    n_state = S_SLOAD;
                end else begin
                    n_op    = r_op + pc_pkg::t_op'(1);
                    n_state = S_MLOAD;
                end
            end
            S_SLOAD: begin
                o_cmd.sq_start = 1'b1;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(PW - 1)) begin
                    n_state = S_DLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.div_start = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(pc_pkg::FRAC_BITS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_cnt       <= '0;
            r_op        <= pc_pkg::OP_NXY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.acc && i_in_last) |=> (r_state == S_MLOAD && r_op == pc_pkg::OP_NXY))
        else $error("last item did not start the product sequence");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= pc_pkg::OP_VV)
        else $error("product code out of range");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(PW))
        else $error("step counter overran");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_out_valid && r_state == S_ACC))
        else $error("loaded result not presented");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && r_out_valid) |-> i_out_ready)
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

>>> rtl/core/pearson_correlation_top.sv
// ----------------------------------------------------------------------------
// pearson_correlation_top: Pearson correlation over paired sample streams
// Throughput: one item per cycle while a set accumulates; no item is taken
//   during the bit-serial multiply, square root and divide that end a set.
// Reset: synchronous, clears sums, count, dropped flag and the result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_top #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input wire        i_clk,
    input wire        i_rst_n,
    pc_in_if.sink     i_in,
    pc_out_if.source  o_out
);

    pc_pkg::t_cmd cmd;

    pc_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    pc_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_x_sample     (i_in.x_sample),
        .i_y_sample     (i_in.y_sample),
        .o_correlation  (o_out.correlation),
        .o_degenerate   (o_out.degenerate),
        .o_overflow     (o_out.overflow),
        .o_sample_count (o_out.sample_count)
    );

endmodule

`default_nettype wire

>>> tb/pc_checker.sv
// ----------------------------------------------------------------------------
// pc_checker: correlation result scoreboard
// Watches the sample and result channels, keeps its own running sums of each
// set, works out the expected Q1.15 coefficient on every last item and
// compares each accepted result, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pc_checker #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pc_in_if           i_in,
    pc_out_if          i_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_seen
);

    typedef struct {
        logic signed [pc_pkg::CORR_W-1:0] correlation;
        logic                             degenerate;
        logic                             overflow;
        logic [pc_pkg::COUNT_W-1:0]       sample_count;
    } t_corr_result;

    t_corr_result corr_queue[$];

    longint pairs;
    longint sx, sy, sxx, syy, sxy;
    bit     dropped;

    function automatic t_corr_result corr_of_set();
        t_corr_result res;
        longint       c, vx, vy;
        logic [127:0] prod, quot;
        logic [63:0]  root, cand, mag;
        c    = pairs * sxy - sx * sy;
        vx   = pairs * sxx - sx * sx;
        vy   = pairs * syy - sy * sy;
        if (vx < 0) vx = 0;
        if (vy < 0) vy = 0;
        prod = 128'(vx) * 128'(vy);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= prod) root = cand;
        end
        res.correlation  = '0;
        res.degenerate   = 1'b0;
        res.overflow     = dropped;
        res.sample_count = pc_pkg::COUNT_W'(pairs);
        if (pairs == 0 || root == 0) begin
            res.degenerate = 1'b1;
        end else begin
            mag  = (c < 0) ? 64'(-c) : 64'(c);
            quot = (128'(mag) << pc_pkg::FRAC_BITS) / 128'(root);
            if (quot > 128'd32768) quot = 128'd32768;
            if (c < 0) begin
                res.correlation = pc_pkg::CORR_W'(-quot);
            end else begin
                if (quot > 128'd32767) quot = 128'd32767;
                res.correlation = pc_pkg::CORR_W'(quot);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_corr_result want;
        longint x, y;
        if (!i_rst_n) begin
            pairs = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
            dropped = 1'b0;
            o_fail_count <= 0;
            o_results_seen <= 0;
            corr_queue.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                x = longint'(i_in.x_sample);
                y = longint'(i_in.y_sample);
                if (pairs < MAX_SAMPLES) begin
                    pairs = pairs + 1;
                    sx = sx + x; sy = sy + y;
                    sxx = sxx + x * x; syy = syy + y * y; sxy = sxy + x * y;
                end else begin
                    dropped = 1'b1;
                end
                if (i_in.last) begin
                    corr_queue.push_back(corr_of_set());
                    pairs = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
                    dropped = 1'b0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                o_results_seen <= o_results_seen + 1;
                if (corr_queue.size() == 0) begin
                    $display("%0t: unexpected result corr=%0d degen=%0b ovf=%0b count=%0d",
                             $time, i_out.correlation, i_out.degenerate,
                             i_out.overflow, i_out.sample_count);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = corr_queue.pop_front();
                    if (want.correlation  !== i_out.correlation  ||
                        want.degenerate   !== i_out.degenerate   ||
                        want.overflow     !== i_out.overflow     ||
                        want.sample_count !== i_out.sample_count) begin
                        $display("%0t: mismatch expected corr=%0d degen=%0b ovf=%0b count=%0d",
                                 $time, want.correlation, want.degenerate,
                                 want.overflow, want.sample_count);
                        $display("%0t:          actual   corr=%0d degen=%0b ovf=%0b count=%0d",
                                 $time, i_out.correlation, i_out.degenerate,
                                 i_out.overflow, i_out.sample_count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= corr_queue.size();
    end

endmodule

`default_nettype wire

>>> tb/pearson_correlation_top_test.sv
// ----------------------------------------------------------------------------
// pearson_correlation_top_test: testbench top for the correlation block
// Drives short directed sets (perfect and inverse correlation, saturation,
// constant data, single-pair sets, field extremes), then random sets, under
// random stalls on both channels and one long result hold-off.
// Checking is done by pc_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_top_test;

    localparam int MAX_PAIRS    = 4096;
    localparam int STALL_LIMIT  = 8000;
    localparam int HOLD_CYCLES  = 2500;
    localparam int SETTLE       = 600;

    logic i_clk;
    logic i_rst_n;

    pc_in_if  in_ch();
    pc_out_if out_ch();

    int  fail_count, pending, results_seen;
    bit  quiet, squeeze_req, squeeze_done;
    int  items_sent, sets_sent, idle_cycles;

    pearson_correlation_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pc_checker #(.MAX_SAMPLES(MAX_PAIRS)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random hold-offs and one long hold
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                squeeze_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_pair(input logic signed [pc_pkg::SAMPLE_W-1:0] x,
                             input logic signed [pc_pkg::SAMPLE_W-1:0] y, input logic l);
        in_ch.valid    <= 1'b1;
        in_ch.x_sample <= x;
        in_ch.y_sample <= y;
        in_ch.last     <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (l) sets_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [pc_pkg::SAMPLE_W-1:0] clamp16(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return pc_pkg::SAMPLE_W'(v);
    endfunction

    function automatic logic signed [pc_pkg::SAMPLE_W-1:0] pick_edge();
        case ($urandom_range(0, 3))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    // one random set: shape of data chosen per set
    task automatic send_random_set(input int len);
        int mode, slope, xi, yi;
        mode  = $urandom_range(0, 4);
        slope = $urandom_range(0, 6) - 3;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: begin
                    xi = int'($signed(16'($urandom)));
                    yi = int'($signed(16'($urandom)));
                end
                1: begin
                    xi = int'($signed(16'($urandom)));
                    yi = xi * slope + $urandom_range(0, 2000) - 1000;
                end
                2: begin
                    xi = $urandom_range(0, 16) - 8;
                    yi = $urandom_range(0, 16) - 8;
                end
                3: begin
                    xi = pick_edge();
                    yi = pick_edge();
                end
                default: begin
                    xi = int'($signed(16'($urandom)));
                    yi = ($urandom_range(0, 9) == 0) ? xi : 1234;
                end
            endcase
            send_pair(clamp16(xi), clamp16(yi), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0 || sets_sent != results_seen) @(posedge i_clk);
    endtask

    initial begin
        int random_items, len;
        in_ch.valid    = 1'b0;
        in_ch.x_sample = '0;
        in_ch.y_sample = '0;
        in_ch.last     = 1'b0;
        quiet = 1'b0; squeeze_req = 1'b0; squeeze_done = 1'b0;
        items_sent = 0; sets_sent = 0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturation to +1 and full-scale -1
        send_pair(16'sd32767, 16'sd32767, 1'b0);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(16'sd32767, -16'sd32768, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd1, 16'sd2, 1'b0);
        send_pair(16'sd2, 16'sd4, 1'b0);
        send_pair(16'sd3, 16'sd6, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(16'sd2, -16'sd2, 1'b1);
        // zero variance: constant x, constant y, single pair
        send_pair(16'sd5, 16'sd1, 1'b0);
        send_pair(16'sd5, 16'sd9, 1'b0);
        send_pair(16'sd5, -16'sd3, 1'b1);
        send_pair(-16'sd7, 16'sd0, 1'b0);
        send_pair(16'sd100, 16'sd0, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sh5555, -16'sh5556, 1'b0);
        send_pair(-16'sh5556, 16'sh5555, 1'b0);
        send_pair(16'sd12, 16'sd40, 1'b1);

        // long result hold-off while sets keep coming
        squeeze_req = 1'b1;
        for (int s = 0; s < 8; s++) send_random_set($urandom_range(2, 6));
        while (!squeeze_done) @(posedge i_clk);

        random_items = 0;
        while (random_items < 700) begin
            if (random_items > 560) quiet = 1'b1;
            case ($urandom_range(0, 19))
                0:       len = 1;
                1:       len = $urandom_range(50, 200);
                default: len = $urandom_range(2, 12);
            endcase
            send_random_set(len);
            random_items += len;
        end
        in_ch.valid <= 1'b0;
        in_ch.last  <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d pairs in %0d sets, %0d results checked", items_sent, sets_sent,
                 results_seen);
        $display("Covered saturation, degenerate sets, a long result hold and random stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
